// ===== hdl/lfe_pkg.sv =====
// Shared types and constants of the line FIR filter with replicated edges.
package lfe_pkg;

   // Fixed field widths of the transaction payloads
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int TAP_IDX_BITS   = 6;
   localparam int TAP_COUNT_BITS = 6;

   // Defaults for the top-level parameters
   localparam int MAX_TAPS_DEFAULT       = 63;
   localparam int COEF_FRAC_BITS_DEFAULT = 15;

   // Register reset value
   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 6'd3;

   // Request action codes
   localparam logic ACTION_COEF   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef struct packed {
      logic                      action;
      logic [TAP_IDX_BITS-1:0]   tap_index;
      logic [COEF_BITS-1:0]      coefficient;
      logic [SAMPLE_BITS-1:0]    sample;
      logic                      last_in_line;
   } lfe_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]    filtered;
      logic                      last_of_line;
   } lfe_rsp_type;

endpackage

// ===== hdl/line_fir_edge_replicate.sv =====
// Line FIR filter with replicated edges (one pass of a separable blur).
//
// Input channel req_*: each transaction either loads one kernel coefficient
// (action = coefficient) or delivers one line sample. Load every tap in use
// before the first sample. The csr_* port writes tap_count; change it only
// while the block is idle. Output channel rsp_*: filtered pixels, with
// last_of_line set on the final pixel of a line.
//
// One shared multiply-accumulate walks the taps: the coefficient RAM and the
// sample ring RAM are each read once per cycle. A sample that completes a
// pixel holds req_ready low while its taps are issued (taps = 2*h + 1,
// h = min(tap_count/2, (MAX_TAPS-1)/2)), the read and product registers
// drain and the pixel waits for a free output register; req_ready rises
// as the pixel shows on rsp. A coefficient load, or a sample that completes
// no pixel, leaves the block idle. A sample flagged last flushes up to h + 1
// pixels, holding req_ready low until the last is out; high while idle.
//
// Reset clears tap_count to 3 and the line position; the RAMs are not
// cleared. A held rsp transaction stalls only the pixel behind it; the next
// request can still be accepted while a pixel waits in the output register.
module line_fir_edge_replicate #(
   parameter int MAX_TAPS       = lfe_pkg::MAX_TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = lfe_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lfe_pkg::lfe_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lfe_pkg::lfe_rsp_type                  rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [lfe_pkg::TAP_COUNT_BITS-1:0]    csr_write_data
);

   localparam int SB       = lfe_pkg::SAMPLE_BITS;
   localparam int CB       = lfe_pkg::COEF_BITS;
   localparam int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW       = $clog2(MAX_TAPS + 1);
   localparam int CMP_W    = (AW > lfe_pkg::TAP_COUNT_BITS) ? AW : lfe_pkg::TAP_COUNT_BITS;
   localparam int HALF_CAP = (MAX_TAPS - 1) / 2;
   localparam int PROD_W   = SB + CB;
   localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);

   localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [lfe_pkg::TAP_COUNT_BITS-1:0]  tap_count_ff;
   logic [CW-1:0]                       seen_ff, seen_in;
   logic [AW-1:0]                       head_ff, head_in;

   // Per-item job context
   logic [AW-1:0] job_head_ff, job_head_in;
   logic [AW-1:0] job_oldest_ff, job_oldest_in;
   logic [AW-1:0] job_h_ff, job_h_in;
   logic [AW-1:0] job_span_ff, job_span_in;
   logic [AW-1:0] center_ff, center_in;
   logic          job_last_ff, job_last_in;
   logic [AW-1:0] tap_ff, tap_in;

   // MAC pipeline
   logic              rd_vld_ff, mul_vld_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   lfe_pkg::lfe_rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire, is_sample, coef_we;
   logic [CW-1:0]    seen_new;
   logic [AW-1:0]    head_new, oldest_new, h_now, top_new;
   logic [CMP_W-1:0] h_raw, h_sel;
   logic [AW:0]      up_w, age_raw, slot_sum;
   logic [AW-1:0]    age, slot;
   logic [CB-1:0]    coef_rd;
   logic [SB-1:0]    smp_rd;
   logic [ACC_W:0]   rnd_sum, rnd_shift;
   logic [SB-1:0]    pixel;
   logic             emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_sample = (req_data.action == lfe_pkg::ACTION_SAMPLE);
   assign coef_we   = req_fire && !is_sample
                      && (32'(req_data.tap_index) < 32'(MAX_TAPS));

   // Line position after this sample and kernel half length
   always_comb begin
      seen_new   = (seen_ff == CW'(MAX_TAPS)) ? seen_ff : seen_ff + CW'(1);
      head_new   = (head_ff == AW'(MAX_TAPS - 1)) ? '0 : head_ff + AW'(1);
      oldest_new = AW'(seen_new - CW'(1));
      h_raw      = CMP_W'(tap_count_ff >> 1);
      h_sel      = (h_raw > CMP_W'(HALF_CAP)) ? CMP_W'(HALF_CAP) : h_raw;
      h_now      = AW'(h_sel);
      top_new    = (oldest_new > h_now) ? h_now : oldest_new;
   end

   // Sample ring slot for the current tap: age clamped into the line
   always_comb begin
      up_w     = {1'b0, center_ff} + {1'b0, job_h_ff};
      age_raw  = ({1'b0, tap_ff} > up_w) ? '0 : up_w - {1'b0, tap_ff};
      age      = (age_raw > {1'b0, job_oldest_ff}) ? job_oldest_ff : age_raw[AW-1:0];
      slot_sum = {1'b0, job_head_ff} + (AW + 1)'(MAX_TAPS - 1) - {1'b0, age};
      slot     = (slot_sum >= (AW + 1)'(MAX_TAPS)) ?
                 AW'(slot_sum - (AW + 1)'(MAX_TAPS)) : slot_sum[AW-1:0];
   end

   lfe_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (AW'(req_data.tap_index)),
      .wr_data (req_data.coefficient),
      .rd_addr (tap_ff),
      .rd_data (coef_rd)
   );

   lfe_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_sample_ram (
      .clock   (clock),
      .wr_en   (req_fire && is_sample),
      .wr_addr (head_ff),
      .wr_data (req_data.sample),
      .rd_addr (slot),
      .rd_data (smp_rd)
   );

   // Round half up, drop fraction bits, saturate
   always_comb begin
      rnd_sum   = {1'b0, acc_ff} + RND_HALF;
      rnd_shift = rnd_sum >> COEF_FRAC_BITS;
      pixel     = (|rnd_shift[ACC_W:SB]) ? '1 : rnd_shift[SB-1:0];
   end

   assign emit = (state_ff == ST_DRAIN) && !rd_vld_ff && !mul_vld_ff
                 && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      head_in       = head_ff;
      job_head_in   = job_head_ff;
      job_oldest_in = job_oldest_ff;
      job_h_in      = job_h_ff;
      job_span_in   = job_span_ff;
      center_in     = center_ff;
      job_last_in   = job_last_ff;
      tap_in        = tap_ff;
      acc_in        = mul_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_sample) begin
               job_head_in   = head_new;
               job_oldest_in = oldest_new;
               job_h_in      = h_now;
               job_span_in   = AW'({h_now, 1'b0});
               job_last_in   = req_data.last_in_line;
               tap_in        = '0;
               acc_in        = '0;
               if (req_data.last_in_line) begin
                  center_in = top_new;
                  seen_in   = '0;
                  head_in   = '0;
                  state_in  = ST_ISSUE;
               end else begin
                  center_in = h_now;
                  seen_in   = seen_new;
                  head_in   = head_new;
                  if (seen_new > CW'(h_now)) begin
                     state_in = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            if (tap_ff == job_span_ff) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.filtered      = pixel;
               rsp_data_in.last_of_line  = job_last_ff && (center_ff == '0);
               if (job_last_ff && (center_ff != '0)) begin
                  center_in = center_ff - AW'(1);
                  tap_in    = '0;
                  acc_in    = '0;
                  state_in  = ST_ISSUE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= lfe_pkg::TAP_COUNT_RESET;
         seen_ff      <= '0;
         head_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         rd_vld_ff    <= (state_ff == ST_ISSUE);
         mul_vld_ff   <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            tap_count_ff <= csr_write_data;
         end
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      job_head_ff   <= job_head_in;
      job_oldest_ff <= job_oldest_in;
      job_h_ff      <= job_h_in;
      job_span_ff   <= job_span_in;
      center_ff     <= center_in;
      job_last_ff   <= job_last_in;
      tap_ff        <= tap_in;
      prod_ff       <= coef_rd * smp_rd;
      acc_ff        <= acc_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/lfe_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module lfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 63
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lfe_checker.sv =====
// Port-level checks for the line FIR filter.
module lfe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input lfe_pkg::lfe_req_type                req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input lfe_pkg::lfe_rsp_type                rsp_data
);

   // Out of reset the block is idle with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A coefficient load finishes in its own cycle
   a_coef_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == lfe_pkg::ACTION_COEF)
      |=> req_ready)
      else $error("coefficient load held the block");

   // A sample flagged last always starts a flush
   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == lfe_pkg::ACTION_SAMPLE)
      && req_data.last_in_line |=> !req_ready)
      else $error("last sample gave no flush");

endmodule

bind line_fir_edge_replicate lfe_checker u_lfe_checker (.*);
